FILE: rtl/hypo_domain_builder_assert.svh
// Assertion macros used by the checker file.
`ifndef HYPO_DOMAIN_BUILDER_ASSERT_SVH
`define HYPO_DOMAIN_BUILDER_ASSERT_SVH
// Implication checked on every rising edge outside reset.
`define HDB_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);
// Next-cycle implication checked outside reset.
`define HDB_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);
`endif

FILE: rtl/hdb_pkg.sv
package hdb_pkg;
	localparam int unsigned POS_W   = 32;
	localparam int unsigned STOP_W  = 33;
	localparam int unsigned COUNT_W = 24;
	localparam int unsigned SCORE_W = 40;
	localparam int unsigned CNT_W   = 16;
	localparam int unsigned REPS_W  = 3;
	localparam int unsigned IN_W    = 160;
	localparam int unsigned USER_W  = 2;
	localparam int unsigned OUT_W   = 136;

	// Site control that travels alongside the fraction lanes.
	typedef struct packed {
		logic              seg;
		logic              eos;
		logic              hypo;
		logic [POS_W-1:0]  pos;
	} site_ctl_t;

	// Closed domain record.
	typedef struct packed {
		logic [POS_W-1:0]   first;
		logic [STOP_W-1:0]  stop;
		logic [COUNT_W-1:0] count;
		logic [SCORE_W-1:0] score;
	} domain_t;
endpackage

FILE: rtl/hdb_divider.sv
// One replicate lane: restoring divider, one quotient bit per stage.
module hdb_divider import hdb_pkg::*; #(
	parameter int unsigned FRACTION_BITS = 16
) (
	input  logic             clk,
	input  logic             adv,
	input  logic             en,
	input  logic [CNT_W-1:0] meth,
	input  logic [CNT_W-1:0] unmeth,
	output logic [CNT_W+FRACTION_BITS-1:0] quot
);
	localparam int unsigned NW = CNT_W + FRACTION_BITS;
	localparam int unsigned DW = CNT_W + 1;
	localparam int unsigned ST = NW;

	logic [NW-1:0] num_q [1:ST];
	logic [NW-1:0] qt_q  [1:ST];
	logic [DW-1:0] rem_q [1:ST];
	logic [DW-1:0] den_q [1:ST];
	logic [DW-1:0] den_in;
	logic [NW-1:0] num_in;

	// Stage zero loads the operands; a zero divisor gives a zero quotient.
	assign den_in = {1'b0, meth} + {1'b0, unmeth};
	assign num_in = (en && den_in != '0) ? {unmeth, {FRACTION_BITS{1'b0}}} : '0;

	for (genvar i = 0; i < ST; i++) begin : g_st
		logic [NW-1:0] num_c;
		logic [NW-1:0] qt_c;
		logic [DW-1:0] rem_c;
		logic [DW-1:0] den_c;
		logic [DW:0]   trial;
		logic          ge;
		if (i == 0) begin : g_load
			assign num_c = num_in;
			assign qt_c  = '0;
			assign rem_c = '0;
			assign den_c = den_in;
		end else begin : g_pass
			assign num_c = num_q[i];
			assign qt_c  = qt_q[i];
			assign rem_c = rem_q[i];
			assign den_c = den_q[i];
		end
		always_comb begin
			trial = {rem_c, num_c[NW-1]};
			ge    = (den_c != '0) && (trial >= {1'b0, den_c});
		end
		always_ff @(posedge clk) begin
			if (adv) begin
				rem_q[i+1] <= DW'(ge ? (trial - {1'b0, den_c}) : trial);
				num_q[i+1] <= {num_c[NW-2:0], 1'b0};
				qt_q[i+1]  <= {qt_c[NW-2:0], ge};
				den_q[i+1] <= den_c;
			end
		end
	end

	assign quot = qt_q[ST];
endmodule

FILE: rtl/hdb_merge.sv
// Sums the lane quotients and runs the domain state; at most two records out.
module hdb_merge import hdb_pkg::*; #(
	parameter int unsigned MAX_REPLICATES = 4,
	parameter int unsigned FRACTION_BITS  = 16
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             go,
	input  site_ctl_t        ctl,
	input  logic [MAX_REPLICATES-1:0][CNT_W+FRACTION_BITS-1:0] quot,
	output logic             busy,
	output logic             out_valid,
	input  logic             out_ready,
	output domain_t          out_dom,
	output logic             out_last
);
	localparam int unsigned QW = CNT_W + FRACTION_BITS;

	logic               inside_q;
	logic [POS_W-1:0]   start_q;
	logic [STOP_W-1:0]  prev_q;
	logic [COUNT_W-1:0] count_q;
	logic [SCORE_W-1:0] score_q;
	domain_t            slot_q [2];
	logic [1:0]         n_q;
	logic               rd_q;

	logic [QW+2:0]      add;
	logic               inside_n;
	logic [POS_W-1:0]   start_n;
	logic [COUNT_W-1:0] count_n;
	logic [SCORE_W-1:0] score_n;
	logic [SCORE_W:0]   sum;
	domain_t            e0, e1;
	logic [1:0]         n;

	// Lane adder.
	always_comb begin
		add = '0;
		for (int r = 0; r < MAX_REPLICATES; r++) add = add + (QW+3)'(quot[r]);
	end

	// Domain update in model order.
	always_comb begin
		inside_n = inside_q; start_n = start_q; count_n = count_q; score_n = score_q;
		n = 2'd0; e0 = '0; e1 = '0; sum = '0;
		if (ctl.seg && inside_n) begin
			e0 = '{start_n, prev_q, count_n, score_n}; n = 2'd1; inside_n = 1'b0;
		end
		if (ctl.hypo) begin
			if (!inside_n) begin
				inside_n = 1'b1; start_n = ctl.pos; count_n = '0; score_n = '0;
			end
			if (count_n != '1) count_n = count_n + 1'b1;
			sum = {1'b0, score_n} + (SCORE_W+1)'(add);
			score_n = sum[SCORE_W] ? '1 : sum[SCORE_W-1:0];
		end else if (inside_n) begin
			if (n == 2'd0) e0 = '{start_n, prev_q, count_n, score_n};
			else e1 = '{start_n, prev_q, count_n, score_n};
			n = n + 2'd1; inside_n = 1'b0;
		end
		if (ctl.eos && inside_n) begin
			if (n == 2'd0) e0 = '{start_n, {1'b0, ctl.pos} + 1'b1, count_n, score_n};
			else e1 = '{start_n, {1'b0, ctl.pos} + 1'b1, count_n, score_n};
			n = n + 2'd1; inside_n = 1'b0;
		end
	end

	// State and output slots.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			inside_q <= 1'b0; start_q <= '0; prev_q <= '0; count_q <= '0;
			score_q <= '0; n_q <= '0; rd_q <= 1'b0;
			slot_q[0] <= '0; slot_q[1] <= '0;
		end else if (go) begin
			inside_q <= inside_n; start_q <= start_n; count_q <= count_n;
			score_q <= score_n; prev_q <= {1'b0, ctl.pos} + 1'b1;
			slot_q[0] <= e0; slot_q[1] <= e1; n_q <= n; rd_q <= 1'b0;
		end else if (out_valid && out_ready) begin
			if (rd_q || n_q == 2'd1) begin
				n_q <= '0; rd_q <= 1'b0;
			end else rd_q <= 1'b1;
		end
	end

	assign busy      = n_q != '0;
	assign out_valid = n_q != '0;
	assign out_dom   = rd_q ? slot_q[1] : slot_q[0];
	assign out_last  = rd_q || n_q == 2'd1;
endmodule

FILE: rtl/hypo_domain_builder.sv
// Hypomethylated domain builder. One site per beat on s_axis, tlast marking the
// final site of the stream; one beat per closed domain on m_axis, tlast marking
// the final record a site caused. Each replicate has its own divider lane,
// FRACTION_BITS+16 stages deep, one quotient bit a stage; a merge stage sums the
// lanes and updates the domain. Sites overlap in the lanes, but the merge stage
// holds the pipe while records wait, so a site that closes domains stalls the
// input until all of its records have been taken.
module hypo_domain_builder import hdb_pkg::*; #(
	parameter int unsigned MAX_REPLICATES = 4,
	parameter int unsigned FRACTION_BITS  = 16
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              cfg_valid,
	output logic              cfg_ready,
	input  logic [REPS_W-1:0] cfg_data,
	input  logic              s_axis_tvalid,
	output logic              s_axis_tready,
	// pos[31:0], then meth[15:0] and unmeth[15:0] for replicates 0..3
	input  logic [IN_W-1:0]   s_axis_tdata,
	// segment start, hypo state
	input  logic [USER_W-1:0] s_axis_tuser,
	input  logic              s_axis_tlast,
	output logic              m_axis_tvalid,
	input  logic              m_axis_tready,
	// first[31:0], stop[32:0], count[23:0], score[39:0], zero pad
	output logic [OUT_W-1:0]  m_axis_tdata,
	output logic              m_axis_tlast
);
	localparam int unsigned QW = CNT_W + FRACTION_BITS;
	localparam int unsigned DEPTH = QW;

	logic [REPS_W-1:0] reps_q;
	logic [DEPTH:1]    vld_q;
	site_ctl_t         ctl_in;
	site_ctl_t         ctl_q [1:DEPTH];
	logic              busy, adv;
	logic [MAX_REPLICATES-1:0][QW-1:0] quot;
	domain_t           dom;

	assign cfg_ready = 1'b1;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) reps_q <= REPS_W'(1);
		else if (cfg_valid) reps_q <= cfg_data;
	end

	// The pipe advances unless records are waiting at the merge stage.
	assign adv = !busy;
	assign s_axis_tready = adv;

	always_comb begin
		ctl_in.seg  = s_axis_tuser[0];
		ctl_in.eos  = s_axis_tlast;
		ctl_in.pos  = s_axis_tdata[POS_W-1:0];
		ctl_in.hypo = s_axis_tuser[1];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) vld_q <= '0;
		else if (adv) vld_q <= {vld_q[DEPTH-1:1], s_axis_tvalid};
	end
	for (genvar i = 0; i < DEPTH; i++) begin : g_ctl
		if (i == 0) begin : g_head
			always_ff @(posedge clk) if (adv) ctl_q[1] <= ctl_in;
		end else begin : g_body
			always_ff @(posedge clk) if (adv) ctl_q[i+1] <= ctl_q[i];
		end
	end

	// Replicate lanes.
	for (genvar r = 0; r < MAX_REPLICATES; r++) begin : g_lane
		hdb_divider #(.FRACTION_BITS(FRACTION_BITS)) u_div (
			.clk(clk), .adv(adv),
			.en({1'b0, reps_q} > (REPS_W+1)'(r)),
			.meth(s_axis_tdata[POS_W+2*CNT_W*r +: CNT_W]),
			.unmeth(s_axis_tdata[POS_W+CNT_W+2*CNT_W*r +: CNT_W]),
			.quot(quot[r]));
	end

	hdb_merge #(.MAX_REPLICATES(MAX_REPLICATES), .FRACTION_BITS(FRACTION_BITS)) u_merge (
		.clk(clk), .arst_n(arst_n), .go(adv && vld_q[DEPTH]), .ctl(ctl_q[DEPTH]),
		.quot(quot), .busy(busy), .out_valid(m_axis_tvalid), .out_ready(m_axis_tready),
		.out_dom(dom), .out_last(m_axis_tlast));

	assign m_axis_tdata = {7'd0, dom.score, dom.count, dom.stop, dom.first};
endmodule

FILE: rtl/hdb_checker.sv
`include "hypo_domain_builder_assert.svh"
// Port-level checks on the domain builder.
module hdb_checker import hdb_pkg::*; (
	input logic             clk,
	input logic             arst_n,
	input logic             s_axis_tready,
	input logic             m_axis_tvalid,
	input logic             m_axis_tready,
	input logic [OUT_W-1:0] m_axis_tdata
);
	`HDB_ASSERT_IMP(a_no_take_while_out, clk, arst_n, m_axis_tvalid, !s_axis_tready, "input taken while records wait")
	`HDB_ASSERT_IMP(a_count_nonzero, clk, arst_n, m_axis_tvalid, m_axis_tdata[88:65] != '0, "empty domain")
	`HDB_ASSERT_NEXT(a_hold, clk, arst_n, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata), "record changed while stalled")
endmodule

bind hypo_domain_builder hdb_checker u_chk (
	.clk(clk), .arst_n(arst_n), .s_axis_tready(s_axis_tready),
	.m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
	.m_axis_tdata(m_axis_tdata));
